// File: design/per_port_bandwidth_estimator_top_defines.svh
// Assertion macros used by the bandwidth estimator top.
`ifndef PER_PORT_BANDWIDTH_ESTIMATOR_TOP_DEFINES_SVH
`define PER_PORT_BANDWIDTH_ESTIMATOR_TOP_DEFINES_SVH

`ifndef SYNTHESIS
// Check a property on every rising edge outside of reset.
`define PPBE_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);
// Check a property on every rising edge, reset included.
`define PPBE_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) (prop)) else $error(msg);
`else
`define PPBE_ASSERT(lbl, prop, msg)
`define PPBE_ASSERT_ALWAYS(lbl, prop, msg)
`endif

`endif

// File: design/ppbe_pkg.sv
package ppbe_pkg;

  // Field widths.
  localparam int PORT_W  = 4;
  localparam int BYTES_W = 16;
  localparam int TIME_W  = 48;
  localparam int RATE_W  = 40;
  localparam int NUM_W   = 60;
  localparam int WIN_W   = 24;
  localparam int ALPHA_W = 17;
  localparam int EN_W    = 16;
  localparam int MAX_SLOTS = 16;

  // Stream beat widths (padded to whole bytes).
  localparam int IN_DATA_W  = 72;
  localparam int OUT_DATA_W = 88;

  // Configuration register indexes.
  localparam logic [1:0] CFG_WINDOW_US   = 2'd0;
  localparam logic [1:0] CFG_ALPHA_Q16   = 2'd1;
  localparam logic [1:0] CFG_PORT_ENABLE = 2'd2;

  // Reset values of the configuration registers.
  localparam logic [WIN_W-1:0]   WINDOW_RESET = 24'd100000;
  localparam logic [ALPHA_W-1:0] ALPHA_RESET  = 17'd39322;
  localparam logic [EN_W-1:0]    ENABLE_RESET = 16'hFFFF;

  localparam logic [ALPHA_W-1:0] ONE_Q16  = 17'd65536;
  localparam logic [19:0]        US_PER_S = 20'd1000000;
  localparam logic [RATE_W-1:0]  RATE_MAX = {RATE_W{1'b1}};

  // Per-port record held in the state memory.
  typedef struct packed {
    logic [RATE_W-1:0] bit_count;
    logic [TIME_W-1:0] window_start;
    logic [RATE_W-1:0] last_sample;
    logic [RATE_W-1:0] last_filtered;
  } port_state_t;

  // Divider status toward the controller.
  typedef struct packed {
    logic busy;
    logic done;
  } div_status_t;

  // Controller states.
  typedef enum logic [2:0] {
    S_IDLE,
    S_EVAL,
    S_MUL,
    S_DSTART,
    S_DIV,
    S_FILT,
    S_EMIT
  } ppbe_state_t;

endpackage

// File: design/ppbe_state_mem.sv
module ppbe_state_mem import ppbe_pkg::*; #(
  parameter int DEPTH = 16,
  parameter int AW    = 4
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          rd_en,
  input  logic [AW-1:0] rd_addr,
  output port_state_t   rd_data,
  input  logic          wr_en,
  input  logic [AW-1:0] wr_addr,
  input  port_state_t   wr_data
);

  port_state_t      mem [DEPTH];
  port_state_t      rd_q;
  logic             rd_valid;
  logic [DEPTH-1:0] valid;

  // Entry storage with registered read.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_q <= mem[rd_addr];
    end
  end

  // Valid bits: an entry never written since reset reads as zero.
  always_ff @(posedge clk) begin
    if (rst) begin
      valid    <= '0;
      rd_valid <= 1'b0;
    end else begin
      if (wr_en) begin
        valid[wr_addr] <= 1'b1;
      end
      if (rd_en) begin
        rd_valid <= valid[rd_addr];
      end
    end
  end

  assign rd_data = rd_valid ? rd_q : '0;

endmodule

// File: design/ppbe_div.sv
module ppbe_div import ppbe_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  input  logic [NUM_W-1:0]  numer,
  input  logic [TIME_W-1:0] denom,
  output logic [RATE_W-1:0] quotient,
  output div_status_t       status
);

  logic [TIME_W-1:0] rem;
  logic [TIME_W-1:0] dvs;
  logic [RATE_W-1:0] shreg;
  logic [5:0]        count;
  logic              busy;
  logic              done;
  logic [TIME_W:0]   trial;
  logic              fits;
  logic              too_big;

  // One restoring step: shift in the next dividend bit and try a subtract.
  assign trial = {rem, shreg[RATE_W-1]} - {1'b0, dvs};
  assign fits  = ~trial[TIME_W];

  // The quotient overflows 40 bits when the top dividend bits reach the divisor.
  assign too_big = {{(TIME_W-(NUM_W-RATE_W)){1'b0}}, numer[NUM_W-1:RATE_W]} >= denom;

  // Control of the bit-serial loop.
  always_ff @(posedge clk) begin
    if (rst) begin
      busy  <= 1'b0;
      done  <= 1'b0;
      count <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        if (too_big) begin
          done <= 1'b1;
        end else begin
          busy  <= 1'b1;
          count <= 6'(RATE_W);
        end
      end else if (busy) begin
        count <= count - 6'd1;
        if (count == 6'd1) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  // Remainder and dividend/quotient shift register.
  always_ff @(posedge clk) begin
    if (start) begin
      dvs <= denom;
      if (too_big) begin
        shreg <= RATE_MAX;
      end else begin
        rem   <= {{(TIME_W-(NUM_W-RATE_W)){1'b0}}, numer[NUM_W-1:RATE_W]};
        shreg <= numer[RATE_W-1:0];
      end
    end else if (busy) begin
      rem   <= fits ? trial[TIME_W-1:0] : {rem[TIME_W-2:0], shreg[RATE_W-1]};
      shreg <= {shreg[RATE_W-2:0], fits};
    end
  end

  assign quotient    = shreg;
  assign status.busy = busy;
  assign status.done = done;

endmodule

// File: design/per_port_bandwidth_estimator_top.sv
// Per-port bandwidth estimator. Each input beat is one sent packet (port,
// byte count, microsecond timestamp). Packets on enabled ports add their bits
// to that port's counter; once more than window_us has passed since the
// port's window start, the block emits one result beat with the window's
// sample rate in bits per second and the low-pass filtered rate, both
// saturated to 40 bits. Items are handled one at a time. A packet on a
// disabled or absent port is taken without a memory access; a packet that
// only counts goes through a memory read, then a write back; a packet that
// closes a window also passes the multiply stage, the bit-serial 40-step
// divider that forms bits * 10^6 / elapsed, and the filter stage. When the
// sample rate saturates the divider skips its bit-serial steps. A closing
// packet also waits while the previous result beat is still held in the
// output register. All per-port state lives in one memory with a registered
// read and is zero after reset. No beat is taken during reset.
// Configuration is written through cfg_we / cfg_index / cfg_data, which the
// user must do only while the block is idle; the block does not enforce it.
module per_port_bandwidth_estimator_top import ppbe_pkg::*; #(
  parameter int NUM_PORTS = 16
) (
  input  logic                  clk,
  input  logic                  rst,
  // Input packets.
  input  logic                  s_tvalid,
  output logic                  s_tready,
  // tdata: port [3:0], packet_bytes [19:4], now_us [67:20], zeros above.
  input  logic [IN_DATA_W-1:0]  s_tdata,
  // Rate results.
  output logic                  m_tvalid,
  input  logic                  m_tready,
  // tdata: out_port [3:0], sample_rate [43:4], filtered_rate [83:44], zeros.
  output logic [OUT_DATA_W-1:0] m_tdata,
  // Configuration writes.
  input  logic                  cfg_we,
  input  logic [1:0]            cfg_index,
  input  logic [WIN_W-1:0]      cfg_data
);

`include "per_port_bandwidth_estimator_top_defines.svh"

  localparam int PORT_SLOTS = (NUM_PORTS > MAX_SLOTS) ? MAX_SLOTS : NUM_PORTS;
  localparam int AW         = (PORT_SLOTS > 1) ? $clog2(PORT_SLOTS) : 1;

  ppbe_state_t state, state_next;

  logic [WIN_W-1:0]   window_us;
  logic [ALPHA_W-1:0] alpha_q16;
  logic [EN_W-1:0]    port_enable;

  logic [PORT_W-1:0]  in_port;
  logic [BYTES_W-1:0] in_bytes;
  logic [TIME_W-1:0]  in_now;
  logic               in_beat;
  logic               eligible;

  logic [PORT_W-1:0]  port_q;
  logic [BYTES_W-1:0] bytes_q;
  logic [TIME_W-1:0]  now_q;
  logic [RATE_W-1:0]  bits_q;
  logic [TIME_W-1:0]  elapsed_q;
  logic [NUM_W-1:0]   num_q;
  logic [56:0]        p1_q;
  logic [57:0]        p2_q;

  port_state_t        rd_data;
  port_state_t        wr_data;
  logic               mem_re;
  logic               mem_we;

  logic [RATE_W:0]    bits_sum;
  logic [RATE_W-1:0]  bits_sat;
  logic [TIME_W-1:0]  elapsed;
  logic               closing;

  logic               div_start;
  logic [RATE_W-1:0]  div_q;
  div_status_t        div_st;

  logic [ALPHA_W-1:0] a_sat;
  logic [ALPHA_W-1:0] one_minus_a;
  logic [RATE_W:0]    sample_sum;
  logic [NUM_W-1:0]   acc;
  logic [NUM_W-18:0]  acc_shift;
  logic [RATE_W-1:0]  filt;
  logic               emit_go;

  // Input beat fields.
  assign in_port  = s_tdata[PORT_W-1:0];
  assign in_bytes = s_tdata[PORT_W+BYTES_W-1:PORT_W];
  assign in_now   = s_tdata[PORT_W+BYTES_W+TIME_W-1:PORT_W+BYTES_W];
  assign in_beat  = s_tvalid && s_tready;
  assign eligible = ({1'b0, in_port} < 5'(PORT_SLOTS)) && port_enable[in_port];

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      window_us   <= WINDOW_RESET;
      alpha_q16   <= ALPHA_RESET;
      port_enable <= ENABLE_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_WINDOW_US:   window_us   <= cfg_data;
        CFG_ALPHA_Q16:   alpha_q16   <= cfg_data[ALPHA_W-1:0];
        CFG_PORT_ENABLE: port_enable <= cfg_data[EN_W-1:0];
        default: ;
      endcase
    end
  end

  // Per-port state memory.
  ppbe_state_mem #(
    .DEPTH (PORT_SLOTS),
    .AW    (AW)
  ) u_mem (
    .clk     (clk),
    .rst     (rst),
    .rd_en   (mem_re),
    .rd_addr (in_port[AW-1:0]),
    .rd_data (rd_data),
    .wr_en   (mem_we),
    .wr_addr (port_q[AW-1:0]),
    .wr_data (wr_data)
  );

  // Rate divider.
  ppbe_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .numer    (num_q),
    .denom    (elapsed_q),
    .quotient (div_q),
    .status   (div_st)
  );

  // Counter update and window check on the fetched entry.
  assign bits_sum = {1'b0, rd_data.bit_count} + (RATE_W+1)'({bytes_q, 3'b000});
  assign bits_sat = bits_sum[RATE_W] ? RATE_MAX : bits_sum[RATE_W-1:0];
  assign elapsed  = now_q - rd_data.window_start;
  assign closing  = elapsed > {{(TIME_W-WIN_W){1'b0}}, window_us};

  // Filter terms.
  assign a_sat       = (alpha_q16 > ONE_Q16) ? ONE_Q16 : alpha_q16;
  assign one_minus_a = ONE_Q16 - a_sat;
  assign sample_sum  = {1'b0, div_q} + {1'b0, rd_data.last_sample};
  assign acc         = NUM_W'({p1_q, 1'b0}) + NUM_W'(p2_q) + NUM_W'(ONE_Q16);
  assign acc_shift   = acc[NUM_W-1:17];
  assign filt        = (acc_shift > (NUM_W-17)'(RATE_MAX)) ? RATE_MAX
                                                            : acc_shift[RATE_W-1:0];

  // Next state.
  always_comb begin
    state_next = state;
    case (state)
      S_IDLE:   if (in_beat && eligible) state_next = S_EVAL;
      S_EVAL:   state_next = closing ? S_MUL : S_IDLE;
      S_MUL:    state_next = S_DSTART;
      S_DSTART: state_next = S_DIV;
      S_DIV:    if (div_st.done) state_next = S_FILT;
      S_FILT:   state_next = S_EMIT;
      S_EMIT:   if (!m_tvalid || m_tready) state_next = S_IDLE;
      default:  state_next = S_IDLE;
    endcase
  end

  // Controller outputs.
  always_comb begin
    s_tready  = 1'b0;
    mem_re    = 1'b0;
    mem_we    = 1'b0;
    div_start = 1'b0;
    emit_go   = 1'b0;
    wr_data   = rd_data;
    case (state)
      S_IDLE: begin
        s_tready = !rst;
        mem_re   = in_beat && eligible;
      end
      S_EVAL: begin
        mem_we            = !closing;
        wr_data.bit_count = bits_sat;
      end
      S_DSTART: begin
        div_start = 1'b1;
      end
      S_EMIT: begin
        emit_go               = !m_tvalid || m_tready;
        mem_we                = emit_go;
        wr_data.bit_count     = '0;
        wr_data.window_start  = now_q;
        wr_data.last_sample   = div_q;
        wr_data.last_filtered = filt;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Datapath registers.
  always_ff @(posedge clk) begin
    if (in_beat) begin
      port_q  <= in_port;
      bytes_q <= in_bytes;
      now_q   <= in_now;
    end
    if (state == S_EVAL) begin
      bits_q    <= bits_sat;
      elapsed_q <= elapsed;
    end
    if (state == S_MUL) begin
      num_q <= NUM_W'(bits_q) * NUM_W'(US_PER_S);
    end
    if (state == S_FILT) begin
      p1_q <= 57'(a_sat) * 57'(rd_data.last_filtered);
      p2_q <= 58'(one_minus_a) * 58'(sample_sum);
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (emit_go) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit_go) begin
      m_tdata <= {{(OUT_DATA_W-PORT_W-2*RATE_W){1'b0}}, filt, div_q, port_q};
    end
  end

  // Design checks.
  `PPBE_ASSERT(a_result_from_emit, $rose(m_tvalid) |-> $past(state) == S_EMIT,
               "result beat raised outside the emit step")
  `PPBE_ASSERT(a_div_done_in_wait, div_st.done |-> state == S_DIV,
               "divider finished while controller was not waiting")
  `PPBE_ASSERT(a_no_write_while_div, mem_we |-> !div_st.busy,
               "state memory written during a division")
  `PPBE_ASSERT_ALWAYS(a_eval_after_read, state == S_EVAL |-> $past(mem_re),
                      "evaluation without a preceding memory read")

endmodule

// File: verif/tb.sv
`timescale 1ns / 100ps

module tb;
  import ppbe_pkg::*;

  localparam int NUM_PORTS = 16;
  localparam int PHASES = 8;
  localparam int PHASE_ITEMS = 250;
  localparam int SETTLE_CYCLES = 64;
  localparam int HOLD_CYCLES = 600;
  localparam int WATCHDOG_LIMIT = 4000;
  // Register index outside the map; writes to it must be dropped.
  localparam logic [1:0] CFG_UNUSED = 2'd3;

  typedef enum logic {ROW_PACKET, ROW_WRITE} row_kind_t;

  // One line of the directed stimulus: a packet or a register write.
  typedef struct {
    row_kind_t   kind;
    logic [3:0]  sel;      // port, or register index
    logic [15:0] nbytes;
    logic [47:0] value;    // timestamp, or register value
    bit          pinned;   // expected rates typed in below
    logic [39:0] pin_sample;
    logic [39:0] pin_filt;
  } stim_row_t;

  typedef struct packed {
    logic [PORT_W-1:0] port;
    logic [RATE_W-1:0] sample;
    logic [RATE_W-1:0] filtered;
  } rate_result_t;

  logic                  clk = 1'b0;
  logic                  rst;
  logic                  s_tvalid;
  logic                  s_tready;
  logic [IN_DATA_W-1:0]  s_tdata;
  logic                  m_tvalid;
  logic                  m_tready;
  logic [OUT_DATA_W-1:0] m_tdata;
  logic                  cfg_we;
  logic [1:0]            cfg_index;
  logic [WIN_W-1:0]      cfg_data;

  // Register copies and per-port meter state of the predictor.
  logic [WIN_W-1:0]   cfg_window;
  logic [ALPHA_W-1:0] cfg_alpha;
  logic [EN_W-1:0]    cfg_enable;
  logic [RATE_W-1:0]  port_bits[NUM_PORTS];
  logic [TIME_W-1:0]  port_start[NUM_PORTS];
  logic [RATE_W-1:0]  port_sample[NUM_PORTS];
  logic [RATE_W-1:0]  port_filt[NUM_PORTS];

  rate_result_t pending_rates[$];
  stim_row_t    dir_rows[$];

  int  mismatches = 0;
  int  packets_sent = 0;
  int  packets_ignored = 0;
  int  rates_checked = 0;
  int  quiet_cycles = 0;
  bit  hold_results = 1'b0;

  per_port_bandwidth_estimator_top #(.NUM_PORTS(NUM_PORTS)) uut (
    .clk(clk),
    .rst(rst),
    .s_tvalid(s_tvalid),
    .s_tready(s_tready),
    .s_tdata(s_tdata),
    .m_tvalid(m_tvalid),
    .m_tready(m_tready),
    .m_tdata(m_tdata),
    .cfg_we(cfg_we),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  // 50 MHz clock.
  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // Idle lengths: mostly none, some short, a few long.
  function automatic int pick_gap();
    int roll;
    roll = $urandom_range(0, 99);
    if (roll < 60) return 0;
    if (roll < 90) return $urandom_range(1, 3);
    return $urandom_range(5, 40);
  endfunction

  // Accumulate a packet into its port's window; on a closing packet, compute the
  // sample and filtered rates, restart the window and return 1.
  function automatic bit predict_rate(input logic [3:0] p, input logic [15:0] nb,
                                      input logic [47:0] stamp, output rate_result_t res);
    logic [63:0] bits;
    logic [47:0] span;
    logic [63:0] elapsed;
    logic [63:0] sample;
    logic [63:0] weight;
    logic [63:0] acc;
    res = '0;
    if (!cfg_enable[p]) return 1'b0;
    bits = 64'(port_bits[p]) + 64'(nb) * 64'd8;
    if (bits > 64'(RATE_MAX)) bits = 64'(RATE_MAX);
    span = stamp - port_start[p];
    elapsed = {16'd0, span};
    if (elapsed <= 64'(cfg_window)) begin
      port_bits[p] = bits[39:0];
      return 1'b0;
    end
    sample = (bits * 64'd1000000) / elapsed;
    if (sample > 64'(RATE_MAX)) sample = 64'(RATE_MAX);
    weight = (cfg_alpha > ONE_Q16) ? 64'(ONE_Q16) : 64'(cfg_alpha);
    acc = 64'd2 * weight * 64'(port_filt[p])
        + (64'(ONE_Q16) - weight) * (sample + 64'(port_sample[p]))
        + 64'(ONE_Q16);
    acc = acc >> 17;
    if (acc > 64'(RATE_MAX)) acc = 64'(RATE_MAX);
    port_sample[p] = sample[39:0];
    port_filt[p] = acc[39:0];
    port_bits[p] = '0;
    port_start[p] = stamp;
    res.port = p;
    res.sample = sample[39:0];
    res.filtered = acc[39:0];
    return 1'b1;
  endfunction

  function automatic void row_packet(input logic [3:0] p, input logic [15:0] nb,
                                     input logic [47:0] stamp, input bit pinned,
                                     input logic [39:0] ps, input logic [39:0] pf);
    stim_row_t r;
    r.kind = ROW_PACKET;
    r.sel = p;
    r.nbytes = nb;
    r.value = stamp;
    r.pinned = pinned;
    r.pin_sample = ps;
    r.pin_filt = pf;
    dir_rows.insert(dir_rows.size(), r);
  endfunction

  function automatic void row_write(input logic [1:0] idx, input logic [23:0] val);
    stim_row_t r;
    r.kind = ROW_WRITE;
    r.sel = {2'b00, idx};
    r.nbytes = '0;
    r.value = {24'd0, val};
    r.pinned = 1'b0;
    r.pin_sample = '0;
    r.pin_filt = '0;
    dir_rows.insert(dir_rows.size(), r);
  endfunction

  task automatic report_mismatch(input string what, input logic [63:0] got,
                                 input logic [63:0] want);
    $display("%0t ns: %s mismatch: got %0d, expected %0d", $time, what, got, want);
    mismatches++;
  endtask

  // Offer one packet beat, wait for it to be taken, then predict its result.
  task automatic send_packet(input logic [3:0] p, input logic [15:0] nb,
                             input logic [47:0] stamp, input bit pinned,
                             input logic [39:0] ps, input logic [39:0] pf, input int gap);
    rate_result_t res;
    bit closes;
    @(negedge clk);
    s_tvalid <= 1'b1;
    s_tdata <= {4'd0, stamp, nb, p};
    do @(posedge clk); while (s_tready !== 1'b1);
    packets_sent++;
    if (!cfg_enable[p]) packets_ignored++;
    closes = predict_rate(p, nb, stamp, res);
    if (pinned) begin
      res.port = p;
      res.sample = ps;
      res.filtered = pf;
      pending_rates.insert(pending_rates.size(), res);
    end else if (closes) begin
      pending_rates.insert(pending_rates.size(), res);
    end
    if (gap > 0) begin
      @(negedge clk);
      s_tvalid <= 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
  endtask

  // Stop offering packets, drain every expected rate, then let the block go idle.
  task automatic settle();
    @(negedge clk);
    s_tvalid <= 1'b0;
    while (pending_rates.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic [1:0] idx, input logic [23:0] val);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(negedge clk);
    cfg_we <= 1'b0;
    case (idx)
      CFG_WINDOW_US:   cfg_window = val;
      CFG_ALPHA_Q16:   cfg_alpha = val[16:0];
      CFG_PORT_ENABLE: cfg_enable = val[15:0];
      default: ;
    endcase
  endtask

  // Result side: ready in runs of random length with random stalls, plus one
  // long hold-off on request so the block backs up into its input.
  initial begin : result_sink
    int run;
    int stall;
    m_tready = 1'b0;
    forever begin
      if (hold_results) begin
        hold_results = 1'b0;
        @(negedge clk);
        m_tready <= 1'b0;
        repeat (HOLD_CYCLES - 1) @(negedge clk);
      end else begin
        run = ($urandom_range(0, 9) == 0) ? $urandom_range(50, 300) : $urandom_range(1, 8);
        stall = pick_gap();
        @(negedge clk);
        m_tready <= 1'b1;
        repeat (run - 1) @(negedge clk);
        if (stall > 0) begin
          @(negedge clk);
          m_tready <= 1'b0;
          repeat (stall - 1) @(negedge clk);
        end
      end
    end
  end

  // Compare each rate beat with the oldest prediction.
  always @(posedge clk) begin : rate_check
    rate_result_t want;
    if (!rst && m_tvalid === 1'b1 && m_tready === 1'b1) begin
      if (pending_rates.size() == 0) begin
        report_mismatch("unexpected rate beat, port", 64'(m_tdata[3:0]), 64'd0);
      end else begin
        want = pending_rates.pop_front();
        if (m_tdata[3:0] !== want.port)
          report_mismatch("out_port", 64'(m_tdata[3:0]), 64'(want.port));
        if (m_tdata[43:4] !== want.sample)
          report_mismatch("sample_rate", 64'(m_tdata[43:4]), 64'(want.sample));
        if (m_tdata[83:44] !== want.filtered)
          report_mismatch("filtered_rate", 64'(m_tdata[83:44]), 64'(want.filtered));
      end
      rates_checked++;
    end
  end

  // Watchdog: too long without any beat on either side means a hang.
  always @(posedge clk) begin
    if ((s_tvalid === 1'b1 && s_tready === 1'b1) || (m_tvalid === 1'b1 && m_tready === 1'b1))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles == WATCHDOG_LIMIT) begin
      $display("Timeout: no beat for %0d cycles", WATCHDOG_LIMIT);
      $display("*** FAILED ***");
      $finish;
    end
  end

  initial begin : stimulus
    int          phase;
    int          made;
    int          roll;
    int          gap;
    int unsigned step_cap;
    bit          pressure_done;
    bit          no_gaps;
    logic [3:0]  p;
    logic [15:0] nb;
    logic [47:0] stamp;
    logic [47:0] now_cursor;
    logic [23:0] win;
    logic [16:0] alpha;
    logic [15:0] en;

    rst = 1'b1;
    s_tvalid = 1'b0;
    s_tdata = '0;
    cfg_we = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    cfg_window = WINDOW_RESET;
    cfg_alpha = ALPHA_RESET;
    cfg_enable = ENABLE_RESET;
    for (int i = 0; i < NUM_PORTS; i++) begin
      port_bits[i] = '0;
      port_start[i] = '0;
      port_sample[i] = '0;
      port_filt[i] = '0;
    end
    pressure_done = 1'b0;

    repeat (3) @(negedge clk);
    rst <= 1'b0;

    // Directed part, reset settings first. Rates are typed in where they are
    // obvious: empty windows, alpha of zero (plain mean) and alpha of one
    // (filtered rate held).
    row_packet(4'd0, 16'd0, 48'd0, 1'b0, '0, '0);
    // Elapsed equal to the window keeps it open.
    row_packet(4'd0, 16'd0, 48'd100000, 1'b0, '0, '0);
    row_packet(4'd0, 16'd0, 48'd100001, 1'b1, 40'd0, 40'd0);
    row_packet(4'd15, 16'hFFFF, 48'hFFFF_FFFF_FFFF, 1'b1, 40'd0, 40'd0);
    // Time going backwards wraps to a huge elapsed time.
    row_packet(4'd0, 16'd125, 48'd50, 1'b1, 40'd0, 40'd0);
    row_write(CFG_ALPHA_Q16, 24'd0);
    row_packet(4'd1, 16'd125, 48'd0, 1'b0, '0, '0);
    row_packet(4'd1, 16'd0, 48'd1000000, 1'b1, 40'd1000, 40'd500);
    row_packet(4'd1, 16'd250, 48'd1000000, 1'b0, '0, '0);
    row_packet(4'd1, 16'd0, 48'd3000000, 1'b1, 40'd1000, 40'd1000);
    row_write(CFG_ALPHA_Q16, 24'd65536);
    row_packet(4'd1, 16'd0, 48'd4000000, 1'b1, 40'd0, 40'd1000);
    // Alpha above one behaves as one.
    row_write(CFG_ALPHA_Q16, 24'h01FFFF);
    row_packet(4'd1, 16'hFFFF, 48'd5000000, 1'b1, 40'd524280, 40'd1000);
    // Zero window: packets at the window start only count; one tick later the
    // window closes and the sample rate saturates.
    row_write(CFG_WINDOW_US, 24'd0);
    row_packet(4'd2, 16'hFFFF, 48'd0, 1'b0, '0, '0);
    row_packet(4'd2, 16'hFFFF, 48'd0, 1'b0, '0, '0);
    row_packet(4'd2, 16'hFFFF, 48'd0, 1'b0, '0, '0);
    row_packet(4'd2, 16'hFFFF, 48'd1, 1'b1, RATE_MAX, 40'd0);
    // A disabled port neither counts nor closes.
    row_write(CFG_PORT_ENABLE, 24'h00FFFB);
    row_packet(4'd2, 16'hFFFF, 48'd9, 1'b0, '0, '0);
    row_packet(4'd3, 16'd1, 48'd1, 1'b1, 40'd8000000, 40'd0);
    row_write(CFG_UNUSED, 24'hFFFFFF);
    row_write(CFG_PORT_ENABLE, 24'h00FFFF);
    row_packet(4'd2, 16'd0, 48'd2, 1'b1, 40'd0, 40'd0);
    row_write(CFG_WINDOW_US, 24'hFFFFFF);
    row_packet(4'd4, 16'hFFFF, 48'd16777215, 1'b0, '0, '0);
    row_packet(4'd4, 16'd0, 48'd16777216, 1'b0, '0, '0);

    foreach (dir_rows[i]) begin
      if (dir_rows[i].kind == ROW_WRITE) begin
        settle();
        write_reg(dir_rows[i].sel[1:0], dir_rows[i].value[23:0]);
      end else begin
        send_packet(dir_rows[i].sel, dir_rows[i].nbytes, dir_rows[i].value,
                    dir_rows[i].pinned, dir_rows[i].pin_sample, dir_rows[i].pin_filt,
                    pick_gap());
      end
    end

    // Random part: a series of register settings, each with a run of packets
    // whose time steps are scaled to the window so that windows close often.
    now_cursor = 48'd16777216;
    for (phase = 0; phase < PHASES; phase++) begin
      no_gaps = 1'b0;
      case (phase)
        0: begin win = 24'd1; alpha = 17'd0; en = 16'hFFFF; no_gaps = 1'b1; end
        1: begin win = 24'd40; alpha = ALPHA_RESET; en = 16'($urandom_range(1, 65535)); end
        2: begin win = 24'd500; alpha = ONE_Q16; en = 16'hFFFF; end
        3: begin win = 24'd0; alpha = 17'h1FFFF; en = 16'($urandom_range(1, 65535)); end
        4: begin
          win = 24'($urandom_range(1, 2000));
          alpha = 17'($urandom_range(0, 131071));
          en = 16'($urandom_range(1, 65535));
        end
        5: begin win = 24'hFFFFFF; alpha = 17'($urandom_range(0, 131071)); en = 16'hFFFF; end
        6: begin win = WINDOW_RESET; alpha = ALPHA_RESET; en = ENABLE_RESET; end
        default: begin win = 24'($urandom_range(1, 300)); alpha = 17'd1; en = 16'h8001; end
      endcase
      settle();
      write_reg(CFG_WINDOW_US, win);
      write_reg(CFG_ALPHA_Q16, {7'($urandom), alpha});
      write_reg(CFG_PORT_ENABLE, {8'($urandom), en});
      write_reg(CFG_UNUSED, 24'($urandom));
      step_cap = 32'(cfg_window) / 3 + 2;

      made = 0;
      while (made < PHASE_ITEMS) begin
        roll = $urandom_range(0, 99);
        if (roll < 12) begin
          // Noise: any port, any timestamp, possibly far back in time.
          p = 4'($urandom_range(0, 15));
          nb = 16'($urandom);
          stamp = 48'({$urandom, $urandom});
          now_cursor = stamp;
        end else begin
          if ($urandom_range(0, 4) == 0) begin
            p = 4'($urandom_range(0, 15));
          end else begin
            do p = 4'($urandom_range(0, 15)); while (!cfg_enable[p]);
          end
          roll = $urandom_range(0, 9);
          nb = (roll == 0) ? 16'd0 : (roll == 1) ? 16'hFFFF : 16'($urandom);
          if ($urandom_range(0, 7) != 0)
            now_cursor = now_cursor + 48'($urandom_range(0, step_cap));
          stamp = now_cursor;
        end
        if (cfg_enable[p]) made++;
        gap = no_gaps ? 0 : pick_gap();
        send_packet(p, nb, stamp, 1'b0, '0, '0, gap);
        if (phase == 2 && made == 60 && !pressure_done) begin
          pressure_done = 1'b1;
          hold_results = 1'b1;
        end
      end
    end

    settle();
    $display("Sent %0d packets (%0d on disabled ports) over %0d random settings", packets_sent,
             packets_ignored, PHASES);
    $display("plus the directed rows; %0d rate beats checked, %0d mismatches.", rates_checked,
             mismatches);
    if (mismatches == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
